>>> src/scanf_format_size_parser_core_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef SCANF_FORMAT_SIZE_PARSER_CORE_MACROS_SVH
`define SCANF_FORMAT_SIZE_PARSER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, masked while in reset
`define SFSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// clocked check that also holds during reset
`define SFSP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SFSP_ASSERT(lbl, prop, msg)
`define SFSP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> src/sfsp_pkg.sv
package sfsp_pkg;

	localparam int unsigned MAX_WIDTH = 65535;
	localparam int unsigned ITEM_CAP  = 131071;
	localparam int unsigned WIDTH_CAP = (MAX_WIDTH < ITEM_CAP) ? MAX_WIDTH : ITEM_CAP;

	// result kinds
	localparam logic [1:0] KIND_ITEM   = 2'd0;
	localparam logic [1:0] KIND_DONE   = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	// length modifiers
	localparam logic [3:0] MOD_NONE  = 4'd0;
	localparam logic [3:0] MOD_HH    = 4'd1;
	localparam logic [3:0] MOD_H     = 4'd2;
	localparam logic [3:0] MOD_L     = 4'd3;
	localparam logic [3:0] MOD_LL    = 4'd4;
	localparam logic [3:0] MOD_J     = 4'd5;
	localparam logic [3:0] MOD_Z     = 4'd6;
	localparam logic [3:0] MOD_T     = 4'd7;
	localparam logic [3:0] MOD_BIG_L = 4'd8;

	// size table columns
	localparam logic [2:0] COL_SIGNED   = 3'd0;
	localparam logic [2:0] COL_UNSIGNED = 3'd1;
	localparam logic [2:0] COL_FLOAT    = 3'd2;
	localparam logic [2:0] COL_CHAR     = 3'd3;
	localparam logic [2:0] COL_PTR      = 3'd4;
	localparam logic [2:0] COL_COUNT    = 3'd5;

	// format characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_BIG_L  = 8'h4C;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_C      = 8'h63;
	localparam logic [7:0] CH_D      = 8'h64;
	localparam logic [7:0] CH_E      = 8'h65;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_G      = 8'h67;
	localparam logic [7:0] CH_H      = 8'h68;
	localparam logic [7:0] CH_I      = 8'h69;
	localparam logic [7:0] CH_J      = 8'h6A;
	localparam logic [7:0] CH_L      = 8'h6C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_O      = 8'h6F;
	localparam logic [7:0] CH_P      = 8'h70;
	localparam logic [7:0] CH_S      = 8'h73;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_Z      = 8'h7A;

	typedef struct packed {
		logic        emit;
		logic [1:0]  kind;
		logic [16:0] item;
		logic [31:0] total;
	} res_t;

	typedef struct packed {
		logic       known;
		logic [2:0] col;
		logic       is_str;
	} conv_t;

	// LP64 sizes; zero marks an illegal pairing
	function automatic logic [4:0] conv_size(input logic [3:0] md, input logic [2:0] col);
		logic [4:0] sz;
		sz = 5'd0;
		case (md)
			MOD_NONE: begin
				case (col)
					COL_SIGNED, COL_UNSIGNED, COL_FLOAT, COL_COUNT: sz = 5'd4;
					COL_CHAR: sz = 5'd1;
					COL_PTR: sz = 5'd8;
					default: sz = 5'd0;
				endcase
			end
			MOD_HH: begin
				if (col == COL_SIGNED || col == COL_UNSIGNED || col == COL_COUNT)
					sz = 5'd1;
			end
			MOD_H: begin
				if (col == COL_SIGNED || col == COL_UNSIGNED || col == COL_COUNT)
					sz = 5'd2;
			end
			MOD_L: begin
				case (col)
					COL_SIGNED, COL_UNSIGNED, COL_FLOAT, COL_COUNT: sz = 5'd8;
					COL_CHAR: sz = 5'd4;
					default: sz = 5'd0;
				endcase
			end
			MOD_LL, MOD_J, MOD_Z, MOD_T: begin
				if (col == COL_SIGNED || col == COL_UNSIGNED || col == COL_COUNT)
					sz = 5'd8;
			end
			MOD_BIG_L: begin
				if (col == COL_FLOAT)
					sz = 5'd16;
			end
			default: sz = 5'd0;
		endcase
		return sz;
	endfunction

	function automatic conv_t conv_class(input logic [7:0] c);
		conv_t r;
		r = '{known: 1'b1, col: COL_SIGNED, is_str: 1'b0};
		case (c)
			CH_D, CH_I: r.col = COL_SIGNED;
			CH_U, CH_O, CH_X: r.col = COL_UNSIGNED;
			CH_F, CH_E, CH_G, CH_A: r.col = COL_FLOAT;
			CH_C: r.col = COL_CHAR;
			CH_S: begin
				r.col    = COL_CHAR;
				r.is_str = 1'b1;
			end
			CH_P: r.col = COL_PTR;
			CH_N: r.col = COL_COUNT;
			default: r.known = 1'b0;
		endcase
		return r;
	endfunction

endpackage

>>> src/scanf_format_size_parser_core.sv
// Each char passes the input register, then the result register. Throughput: one char per
// cycle unless a result stalls; the parse state updates in the single step between them.
// While a result waits unaccepted in the output register, the input register holds at most
// one char, char_ready low once full. Reset (arst_n low, asynchronous): both registers empty,
// parser back to literal text, running total and error flag cleared.
`include "scanf_format_size_parser_core_macros.svh"

module scanf_format_size_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [7:0]  char_code,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  result_kind,
	output logic [16:0] item_bytes,
	output logic [31:0] total_bytes
);
	import sfsp_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [16:0] item_q;
	logic [31:0] total_q;
	logic        adv;
	logic        step;
	res_t        res;

	// result slot is free or being drained this cycle
	assign adv        = !out_valid_q || result_ready;
	assign step       = valid_s1 && adv;
	assign char_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (char_ready)
			valid_s1 <= char_valid;
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid)
			char_s1 <= char_code;
	end

	sfsp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_code (char_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= step && res.emit;
	end

	always_ff @(posedge clk) begin
		if (step && res.emit) begin
			kind_q  <= res.kind;
			item_q  <= res.item;
			total_q <= res.total;
		end
	end

	assign result_valid = out_valid_q;
	assign result_kind  = kind_q;
	assign item_bytes   = item_q;
	assign total_bytes  = total_q;

	`SFSP_ASSERT(a_done_no_item, (result_valid && result_kind == KIND_DONE) |-> item_bytes == 17'd0, "string end carries item bytes")
	`SFSP_ASSERT(a_item_cap, result_valid |-> item_bytes <= 17'(WIDTH_CAP) + 17'd1, "item bytes above width cap")
	`SFSP_ASSERT(a_s1_hold, (valid_s1 && !adv) |=> (valid_s1 && $stable(char_s1)), "input stage lost a stalled item")

endmodule

>>> src/sfsp_parser.sv
`include "scanf_format_size_parser_core_macros.svh"

module sfsp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        char_code,
	output sfsp_pkg::res_t    res
);
	import sfsp_pkg::*;

	typedef enum logic [6:0] {
		PH_LIT   = 7'b0000001,
		PH_PCT   = 7'b0000010,
		PH_WIDTH = 7'b0000100,
		PH_HMOD  = 7'b0001000,
		PH_LMOD  = 7'b0010000,
		PH_CONV  = 7'b0100000,
		PH_SET   = 7'b1000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [16:0] width_q, width_d;
	logic        supp_q, supp_d;
	logic [3:0]  mod_q, mod_d;
	logic [31:0] run_q, run_d;
	logic        error_q, error_d;

	logic        digit;
	logic [3:0]  dval;
	logic [20:0] wsum;
	logic [16:0] wnext;
	conv_t       cls;
	logic        to_mc, to_conv, to_acc, fail_f;
	logic [2:0]  acc_col;
	logic        acc_str;
	logic [4:0]  tsize;
	logic [16:0] sz;
	logic [32:0] sum33;

	assign digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign dval  = 4'(char_code - CH_ZERO);
	// width*10 + digit, clamped
	assign wsum  = (21'(width_q) << 3) + (21'(width_q) << 1) + 21'(dval);
	assign wnext = (wsum > 21'(WIDTH_CAP)) ? 17'(WIDTH_CAP) : wsum[16:0];
	assign cls   = conv_class(char_code);

	always_comb begin
		phase_d = phase_q;
		width_d = width_q;
		supp_d  = supp_q;
		mod_d   = mod_q;
		run_d   = run_q;
		error_d = error_q;
		res     = '{emit: 1'b0, kind: KIND_ITEM, item: 17'd0, total: run_q};
		to_mc   = 1'b0;
		to_conv = 1'b0;
		to_acc  = 1'b0;
		fail_f  = 1'b0;
		acc_col = cls.col;
		acc_str = cls.is_str;
		tsize   = 5'd0;
		sz      = 17'd0;
		sum33   = 33'd0;

		if (char_code == CH_NUL) begin
			res.emit = 1'b1;
			if (error_q || phase_q != PH_LIT) begin
				res.kind  = KIND_REJECT;
				res.total = 32'd0;
			end else begin
				res.kind = KIND_DONE;
			end
			phase_d = PH_LIT;
			width_d = 17'd0;
			supp_d  = 1'b0;
			mod_d   = MOD_NONE;
			run_d   = 32'd0;
			error_d = 1'b0;
		end else begin
			case (phase_q)
				PH_LIT: begin
					if (char_code == CH_PCT && !error_q) begin
						phase_d = PH_PCT;
						width_d = 17'd0;
						supp_d  = 1'b0;
						mod_d   = MOD_NONE;
					end
				end
				PH_PCT: begin
					if (char_code == CH_PCT) begin
						res.emit = 1'b1;
						phase_d  = PH_LIT;
						width_d  = 17'd0;
						supp_d   = 1'b0;
						mod_d    = MOD_NONE;
					end else if (char_code == CH_STAR) begin
						supp_d  = 1'b1;
						phase_d = PH_WIDTH;
					end else if (digit) begin
						width_d = wnext;
						phase_d = PH_WIDTH;
					end else begin
						to_mc = 1'b1;
					end
				end
				PH_WIDTH: begin
					if (digit)
						width_d = wnext;
					else
						to_mc = 1'b1;
				end
				PH_HMOD: begin
					if (char_code == CH_H) begin
						mod_d   = MOD_HH;
						phase_d = PH_CONV;
					end else begin
						mod_d   = MOD_H;
						to_conv = 1'b1;
					end
				end
				PH_LMOD: begin
					if (char_code == CH_L) begin
						mod_d   = MOD_LL;
						phase_d = PH_CONV;
					end else begin
						mod_d   = MOD_L;
						to_conv = 1'b1;
					end
				end
				PH_CONV: begin
					to_conv = 1'b1;
				end
				PH_SET: begin
					if (char_code == CH_RBRACK) begin
						to_acc  = 1'b1;
						acc_col = COL_CHAR;
						acc_str = 1'b1;
					end
				end
				default: begin
					phase_d = PH_LIT;
				end
			endcase

			if (to_mc) begin
				case (char_code)
					CH_H: phase_d = PH_HMOD;
					CH_L: phase_d = PH_LMOD;
					CH_J: begin
						mod_d   = MOD_J;
						phase_d = PH_CONV;
					end
					CH_Z: begin
						mod_d   = MOD_Z;
						phase_d = PH_CONV;
					end
					CH_T: begin
						mod_d   = MOD_T;
						phase_d = PH_CONV;
					end
					CH_BIG_L: begin
						mod_d   = MOD_BIG_L;
						phase_d = PH_CONV;
					end
					default: to_conv = 1'b1;
				endcase
			end

			if (to_conv) begin
				if (char_code == CH_LBRACK)
					phase_d = PH_SET;
				else if (cls.known)
					to_acc = 1'b1;
				else
					fail_f = 1'b1;
			end

			if (to_acc) begin
				tsize = conv_size(mod_d, acc_col);
				if (tsize == 5'd0) begin
					fail_f = 1'b1;
				end else begin
					if (supp_q)
						sz = 17'd0;
					else if (acc_str)
						sz = width_q + 17'd1;
					else
						sz = 17'(tsize);
					sum33     = {1'b0, run_q} + 33'(sz);
					run_d     = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
					res.emit  = 1'b1;
					res.item  = sz;
					res.total = run_d;
					phase_d   = PH_LIT;
					width_d   = 17'd0;
					supp_d    = 1'b0;
					mod_d     = MOD_NONE;
				end
			end

			if (fail_f) begin
				error_d = 1'b1;
				phase_d = PH_LIT;
				width_d = 17'd0;
				supp_d  = 1'b0;
				mod_d   = MOD_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LIT;
			width_q <= 17'd0;
			supp_q  <= 1'b0;
			mod_q   <= MOD_NONE;
			run_q   <= 32'd0;
			error_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			width_q <= width_d;
			supp_q  <= supp_d;
			mod_q   <= mod_d;
			run_q   <= run_d;
			error_q <= error_d;
		end
	end

	`SFSP_ASSERT(a_err_in_lit, error_q |-> phase_q == PH_LIT, "error latched outside literal phase")
	`SFSP_ASSERT(a_term_clears, (step && char_code == CH_NUL) |=> (!error_q && phase_q == PH_LIT && run_q == 32'd0), "terminator did not restart the parser")
	`SFSP_ASSERT_ALWAYS(a_reject_zero, (res.emit && res.kind == KIND_REJECT) |-> (res.total == 32'd0 && res.item == 17'd0), "reject carries nonzero payload")

endmodule
